/* src/rtd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_pkg: shared types and constants of the rotary encoder tick decoder
// Holds the configuration register map, reset values, phase and direction
// codes, and the structs passed between the decoder modules.
// ----------------------------------------------------------------------------
package rtd_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_RELOAD   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  SLOW_THRESHOLD_RST   = 8'd50;
    localparam logic [7:0]  MEDIUM_THRESHOLD_RST = 8'd20;
    localparam logic [7:0]  FAST_THRESHOLD_RST   = 8'd10;
    localparam logic [15:0] TIMEOUT_RELOAD_RST   = 16'd732;

    // Encoder phase codes (bit1 terminal A, bit0 terminal B)
    localparam logic [1:0] PHASE_DETENT = 2'd3;
    localparam logic [1:0] PHASE_CW     = 2'd2;
    localparam logic [1:0] PHASE_CCW    = 2'd1;

    // Gap counter saturation point
    localparam logic [7:0] GAP_MAX = 8'd255;

    // Direction of the last step
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    // One sampled tick as held in the input register
    typedef struct packed {
        logic       restart_timeout;
        logic       extra_pressed;
        logic       knob_pressed;
        logic [1:0] phase;
    } tick_t;

    // Button edges and timeout flag of one tick
    typedef struct packed {
        logic knob_rise;
        logic knob_fall;
        logic extra_rise;
        logic extra_fall;
        logic timeout_hit;
    } evt_t;

    // Threshold set for the speed magnitude
    typedef struct packed {
        logic [7:0] slow;
        logic [7:0] mid;
        logic [7:0] fast;
    } thr_t;

endpackage : rtd_pkg
`default_nettype wire

/* src/rtd_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_encoder: quadrature step decoder with speed-dependent magnitude
// Detects leaving the detent, tracks direction and tick gap, and returns
// the signed step of the current tick. State advances on tick_en.
// ----------------------------------------------------------------------------
module rtd_encoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tick_en,
    input  wire logic [1:0]         phase,
    input  wire rtd_pkg::thr_t      thr,
    output logic signed [3:0]       step
);

    logic [1:0]    prev_phase_reg, prev_phase_next;
    logic [7:0]    gap_reg, gap_next;
    rtd_pkg::dir_t dir_reg, dir_next;

    logic       leave_cw;
    logic       leave_ccw;
    logic [2:0] speed_mag;
    logic [2:0] mag;

    // Pick magnitude from the gap, thresholds checked slow to fast
    always_comb begin
        priority if (gap_reg > thr.slow) begin
            speed_mag = 3'd1;
        end else if (gap_reg > thr.mid) begin
            speed_mag = 3'd2;
        end else if (gap_reg > thr.fast) begin
            speed_mag = 3'd3;
        end else begin
            speed_mag = 3'd4;
        end
    end

    assign leave_cw  = (prev_phase_reg == rtd_pkg::PHASE_DETENT) &&
                       (phase == rtd_pkg::PHASE_CW);
    assign leave_ccw = (prev_phase_reg == rtd_pkg::PHASE_DETENT) &&
                       (phase == rtd_pkg::PHASE_CCW);

    // Decode step, direction and gap update
    always_comb begin
        mag             = 3'd0;
        dir_next        = dir_reg;
        gap_next        = gap_reg;
        prev_phase_next = phase;
        priority if (leave_cw) begin
            mag      = (dir_reg == rtd_pkg::DIR_CW) ? speed_mag : 3'd1;
            dir_next = rtd_pkg::DIR_CW;
            gap_next = 8'd0;
        end else if (leave_ccw) begin
            mag      = (dir_reg == rtd_pkg::DIR_CCW) ? speed_mag : 3'd1;
            dir_next = rtd_pkg::DIR_CCW;
            gap_next = 8'd0;
        end else if (gap_reg != rtd_pkg::GAP_MAX) begin
            gap_next = gap_reg + 8'd1;
        end else begin
            // hold the saturated gap
            gap_next = rtd_pkg::GAP_MAX;
        end
    end

    // Negate for counter-clockwise
    assign step = leave_ccw ? $signed(4'd0 - {1'b0, mag}) : $signed({1'b0, mag});

    // Hold state between ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_phase_reg <= 2'd0;
            gap_reg        <= 8'd0;
            dir_reg        <= rtd_pkg::DIR_NONE;
        end else if (tick_en) begin
            prev_phase_reg <= prev_phase_next;
            gap_reg        <= gap_next;
            dir_reg        <= dir_next;
        end
    end

endmodule : rtd_encoder
`default_nettype wire

/* src/rtd_events.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtd_events: button edge detection and timeout down-counter
// Compares button levels against the previous tick and runs a reloadable
// counter that flags reaching zero. State advances on tick_en.
// ----------------------------------------------------------------------------
module rtd_events (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        tick_en,
    input  wire logic        knob_pressed,
    input  wire logic        extra_pressed,
    input  wire logic        restart_timeout,
    input  wire logic [15:0] timeout_reload,
    output rtd_pkg::evt_t    evt
);

    logic        knob_old_reg, knob_old_next;
    logic        extra_old_reg, extra_old_next;
    logic [15:0] timeout_reg, timeout_next;
    logic        hit;

    // Button edges against the old levels
    assign evt.knob_rise  = knob_pressed & ~knob_old_reg;
    assign evt.knob_fall  = ~knob_pressed & knob_old_reg;
    assign evt.extra_rise = extra_pressed & ~extra_old_reg;
    assign evt.extra_fall = ~extra_pressed & extra_old_reg;
    assign evt.timeout_hit = hit;

    assign knob_old_next  = knob_pressed;
    assign extra_old_next = extra_pressed;

    // Reload on restart, otherwise count down while nonzero
    always_comb begin
        timeout_next = timeout_reg;
        hit          = 1'b0;
        if (restart_timeout) begin
            timeout_next = timeout_reload;
        end else if (timeout_reg != 16'd0) begin
            timeout_next = timeout_reg - 16'd1;
            hit          = (timeout_reg == 16'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knob_old_reg  <= 1'b0;
            extra_old_reg <= 1'b0;
            timeout_reg   <= 16'd0;
        end else if (tick_en) begin
            knob_old_reg  <= knob_old_next;
            extra_old_reg <= extra_old_next;
            timeout_reg   <= timeout_next;
        end
    end

endmodule : rtd_events
`default_nettype wire

/* src/rotary_encoder_tick_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_tick_decoder: quadrature knob decoder driven by timer ticks
// Each input transfer is one tick; each tick yields exactly one result.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one sampled tick per transfer: encoder phase,
//   two button levels and a timeout restart request. The m_ channel returns
//   one result per tick: signed step (-4..4), four button edge flags, the
//   timeout flag and a wake flag that ORs all events.
//   A tick passes an input register, then the decode logic, then the result
//   register, which drives m_tvalid. Throughput is one tick per cycle while
//   the receiver keeps m_tready high; decoder state is updated as a tick
//   moves from the input register into the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more tick; s_tready drops only when both are
//   full.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   decoder state and loads the configuration registers with their defaults.
//   Configuration is written via cfg_wr_en/cfg_index/cfg_wdata, one register
//   per cycle, by the user only while no tick is in flight (unchecked).
// ----------------------------------------------------------------------------
module rotary_encoder_tick_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [rtd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rtd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Tick input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] phase, [2] knob_pressed, [3] extra_pressed, [4] restart_timeout
    input  wire logic [7:0]                      s_tdata,
    // Result output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] step, [4] knob_rise, [5] knob_fall, [6] extra_rise,
    // [7] extra_fall, [8] timeout_hit, [9] wake
    output logic [15:0]                          m_tdata
);

    rtd_pkg::thr_t  thr_reg;
    logic [15:0]    reload_reg;

    logic           in_valid_reg;
    rtd_pkg::tick_t in_tick_reg;
    logic           res_valid_reg;
    logic [9:0]     res_data_reg;

    logic           advance;
    logic           s_fire;
    logic signed [3:0] step;
    rtd_pkg::evt_t  evt;
    logic           wake;
    logic [9:0]     res_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.slow   <= rtd_pkg::SLOW_THRESHOLD_RST;
            thr_reg.mid    <= rtd_pkg::MEDIUM_THRESHOLD_RST;
            thr_reg.fast   <= rtd_pkg::FAST_THRESHOLD_RST;
            reload_reg     <= rtd_pkg::TIMEOUT_RELOAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rtd_pkg::REG_SLOW_THRESHOLD:   thr_reg.slow   <= cfg_wdata[7:0];
                rtd_pkg::REG_MEDIUM_THRESHOLD: thr_reg.mid    <= cfg_wdata[7:0];
                rtd_pkg::REG_FAST_THRESHOLD:   thr_reg.fast   <= cfg_wdata[7:0];
                rtd_pkg::REG_TIMEOUT_RELOAD:   reload_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: move tick on when the result register is free or draining
    assign advance  = in_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_tick_reg <= rtd_pkg::tick_t'(s_tdata[4:0]);
        end
    end

    rtd_encoder u_encoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .phase   (in_tick_reg.phase),
        .thr     (thr_reg),
        .step    (step)
    );

    rtd_events u_events (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_en         (advance),
        .knob_pressed    (in_tick_reg.knob_pressed),
        .extra_pressed   (in_tick_reg.extra_pressed),
        .restart_timeout (in_tick_reg.restart_timeout),
        .timeout_reload  (reload_reg),
        .evt             (evt)
    );

    // Combine into one result word
    assign wake = (step != 4'sd0) || evt.knob_rise || evt.knob_fall ||
                  evt.extra_rise || evt.extra_fall || evt.timeout_hit;

    assign res_next = {wake, evt.timeout_hit, evt.extra_fall, evt.extra_rise,
                       evt.knob_fall, evt.knob_rise, step};

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_data_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'd0, res_data_reg};

endmodule : rotary_encoder_tick_decoder
`default_nettype wire
